// ----- rtl/signed_int_to_base_digits_unit_defines.svh -----
// Assertion macros shared by the signed_int_to_base_digits_unit RTL.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef SIGNED_INT_TO_BASE_DIGITS_UNIT_DEFINES_SVH
`define SIGNED_INT_TO_BASE_DIGITS_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SI2BD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SI2BD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/si2bd_pkg.sv -----
// Package for the signed integer to base digits unit: widths, register
// indexes, special characters and the status structs. No dependencies.
package si2bd_pkg;

    localparam int unsigned VALUE_W       = 32;
    localparam int unsigned CHAR_W        = 8;
    localparam int unsigned LEN_W         = 5;
    localparam int unsigned CFG_W         = 64;
    localparam int unsigned CFG_IDX_W     = 2;
    localparam int unsigned CHARS_PER_REG = CFG_W / CHAR_W;

    // The divider retires this many quotient bits per cycle.
    localparam int unsigned DIV_BITS  = 8;
    localparam int unsigned DIV_CYC   = VALUE_W / DIV_BITS;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_CYC);

    localparam int unsigned MAX_DIGITS   = VALUE_W;
    localparam int unsigned DIGIT_IDX_W  = $clog2(MAX_DIGITS);
    localparam int unsigned DIGIT_PTR_W  = DIGIT_IDX_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HI = 2'd2;

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

    localparam logic [LEN_W-1:0] MIN_BASE = 5'd2;

    typedef struct packed {
        logic done;
        logic ok;
    } t_chk_stat;

    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] quot;
        logic [LEN_W-1:0]   rem;
    } t_div_res;

endpackage

// ----- rtl/si2bd_div.sv -----
// Shared radix divider: divides a 32-bit magnitude by the radix with a
// restoring shift-subtract, DIV_BITS quotient bits per cycle. Uses si2bd_pkg.
`include "signed_int_to_base_digits_unit_defines.svh"

module si2bd_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [si2bd_pkg::VALUE_W-1:0]    i_dividend,
    input  logic [si2bd_pkg::LEN_W-1:0]      i_divisor,
    output si2bd_pkg::t_div_res              o_res
);
    import si2bd_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [VALUE_W-1:0]   r_q, n_q;
    logic [LEN_W-1:0]     r_rem, n_rem;
    logic [LEN_W-1:0]     r_dvs, n_dvs;

    logic [VALUE_W-1:0]   s_q;
    logic [LEN_W-1:0]     s_rem;
    logic [LEN_W:0]       s_trial;

    // Dividend bits leave at the top of r_q while quotient bits enter at the
    // bottom, so once every dividend bit has been shifted out r_q holds the whole quotient.
    always_comb begin
        s_q     = r_q;
        s_rem   = r_rem;
        s_trial = '0;
        for (int s = 0; s < DIV_BITS; s++) begin
            s_trial = {s_rem, s_q[VALUE_W-1]};
            s_q     = {s_q[VALUE_W-2:0], 1'b0};
            if (s_trial >= {1'b0, r_dvs}) begin
                s_trial = s_trial - {1'b0, r_dvs};
                s_q[0]  = 1'b1;
            end
            s_rem = s_trial[LEN_W-1:0];
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_q   = s_q;
            n_rem = s_rem;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_CYC - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_res = '{done: r_done, quot: r_q, rem: r_rem};

    `SI2BD_ASSERT_IMPL(a_div_rem_range, r_done, r_rem < r_dvs, "remainder not below divisor")
    `SI2BD_ASSERT_IMPL(a_div_start_idle, i_start, !r_busy, "divider restarted while busy")
    `SI2BD_ASSERT_NEXT(a_div_finish, r_busy && (r_cnt == DIV_CNT_W'(DIV_CYC - 1)), r_done,
        "divider missed its done pulse")

endmodule

// ----- rtl/si2bd_alpha.sv -----
// Alphabet store and checker: holds the radix and digit characters, scans
// the alphabet one character per cycle for validity, maps digits to text.
// Uses si2bd_pkg.
`include "signed_int_to_base_digits_unit_defines.svh"

module si2bd_alpha #(
    parameter  int unsigned MAX_BASE = 16,
    localparam int unsigned IDX_W    = $clog2(MAX_BASE)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [si2bd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [si2bd_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                            i_chk_start,
    output si2bd_pkg::t_chk_stat            o_chk,
    output logic [si2bd_pkg::LEN_W-1:0]     o_base_len,
    input  logic [IDX_W-1:0]                i_digit,
    output logic [si2bd_pkg::CHAR_W-1:0]    o_char
);
    import si2bd_pkg::*;

    logic [LEN_W-1:0]                 r_base_len;
    logic [MAX_BASE-1:0][CHAR_W-1:0]  r_alpha;

    logic             r_scan, n_scan;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_done, n_done;
    logic             r_ok, n_ok;

    logic [CHAR_W-1:0] cur;
    logic              len_ok;
    logic              bad_sym;
    logic              dup;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_len <= '0;
        end else if (i_cfg_we && (i_cfg_idx == REG_BASE_LEN)) begin
            r_base_len <= i_cfg_data[LEN_W-1:0];
        end
    end

    // Only the first MAX_BASE characters can ever be part of a valid alphabet.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= '0;
        end else if (i_cfg_we) begin
            for (int k = 0; k < MAX_BASE; k++) begin
                if (i_cfg_idx == ((k < CHARS_PER_REG) ? REG_ALPHA_LO : REG_ALPHA_HI)) begin
                    r_alpha[k] <= i_cfg_data[CHAR_W*(k % CHARS_PER_REG) +: CHAR_W];
                end
            end
        end
    end

    assign len_ok  = (r_base_len >= MIN_BASE) && (r_base_len <= LEN_W'(MAX_BASE));
    assign cur     = r_alpha[r_idx];
    assign bad_sym = (cur == CH_NUL) || (cur == CH_MINUS) || (cur == CH_PLUS);

    // Compare the current character against every later one in use.
    always_comb begin
        dup = 1'b0;
        for (int j = 0; j < MAX_BASE; j++) begin
            if ((LEN_W'(j) > LEN_W'(r_idx)) && (LEN_W'(j) < r_base_len)
                    && (r_alpha[j] == cur)) begin
                dup = 1'b1;
            end
        end
    end

    always_comb begin
        n_scan = r_scan;
        n_idx  = r_idx;
        n_done = 1'b0;
        n_ok   = r_ok;
        if (i_chk_start) begin
            if (len_ok) begin
                n_scan = 1'b1;
                n_idx  = '0;
            end else begin
                n_done = 1'b1;
                n_ok   = 1'b0;
            end
        end else if (r_scan) begin
            if (bad_sym || dup) begin
                n_scan = 1'b0;
                n_done = 1'b1;
                n_ok   = 1'b0;
            end else if (LEN_W'(r_idx) == (r_base_len - LEN_W'(1))) begin
                n_scan = 1'b0;
                n_done = 1'b1;
                n_ok   = 1'b1;
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= 1'b0;
            r_idx  <= '0;
            r_done <= 1'b0;
            r_ok   <= 1'b0;
        end else begin
            r_scan <= n_scan;
            r_idx  <= n_idx;
            r_done <= n_done;
            r_ok   <= n_ok;
        end
    end

    assign o_chk      = '{done: r_done, ok: r_ok};
    assign o_base_len = r_base_len;
    assign o_char     = r_alpha[i_digit];

    `SI2BD_ASSERT_IMPL(a_alpha_ok_len, r_done && r_ok, len_ok, "alphabet passed with bad radix")
    `SI2BD_ASSERT_IMPL(a_alpha_idx_range, r_scan, LEN_W'(r_idx) < r_base_len,
        "scan index beyond radix")
    `SI2BD_ASSERT_IMPL(a_alpha_start_idle, i_chk_start, !r_scan, "check restarted during scan")

endmodule

// ----- rtl/signed_int_to_base_digits_unit.sv -----
// A word is first checked (the radix range, then the alphabet), then each digit is
// formed in the shared divider, then one character is sent per cycle; the next word
// is taken when busy drops. Outputs are registered and cannot be stalled; i_rst_n
// (synchronous) clears the radix, the alphabet and all control state.
`include "signed_int_to_base_digits_unit_defines.svh"

module signed_int_to_base_digits_unit #(
    parameter int unsigned MAX_BASE = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [si2bd_pkg::VALUE_W-1:0] i_value,
    input  logic                                 i_cfg_we,
    input  logic [si2bd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [si2bd_pkg::CFG_W-1:0]          i_cfg_data,
    output logic                                 o_strobe,
    output logic [si2bd_pkg::CHAR_W-1:0]         o_ch,
    output logic                                 o_last
);
    import si2bd_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_BASE);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_DIV   = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic                r_neg, n_neg;
    logic [VALUE_W-1:0]  r_mag, n_mag;
    logic [DIGIT_PTR_W-1:0] r_nd, n_nd;
    logic [IDX_W-1:0]    r_digits [MAX_DIGITS];
    logic [IDX_W-1:0]    r_top_digit;
    logic                r_strobe, n_strobe;
    logic [CHAR_W-1:0]   r_ch, n_ch;
    logic                r_last, n_last;

    logic                accept;
    logic                push;
    logic                div_start;
    logic [VALUE_W-1:0]  div_dividend;
    logic [VALUE_W-1:0]  value_u;
    logic [DIGIT_PTR_W-1:0] rd_ptr;
    logic [DIGIT_PTR_W-1:0] top_ptr;
    logic [IDX_W-1:0]    rd_digit;
    logic [CHAR_W-1:0]   digit_char;
    logic [LEN_W-1:0]    base_len;
    t_chk_stat           chk;
    t_div_res            div;

    assign accept   = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);
    assign value_u  = i_value;
    assign rd_ptr   = r_nd - DIGIT_PTR_W'(1);
    assign top_ptr  = n_nd - DIGIT_PTR_W'(1);
    assign rd_digit = r_top_digit;

    si2bd_alpha #(
        .MAX_BASE (MAX_BASE)
    ) u_alpha (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_chk_start (accept),
        .o_chk       (chk),
        .o_base_len  (base_len),
        .i_digit     (rd_digit),
        .o_char      (digit_char)
    );

    si2bd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (base_len),
        .o_res      (div)
    );

    // Digits come out of the divider least significant first; they are
    // stacked and sent back out in reverse order.
    always_comb begin
        n_state      = r_state;
        n_neg        = r_neg;
        n_mag        = r_mag;
        n_nd         = r_nd;
        n_strobe     = 1'b0;
        n_ch         = r_ch;
        n_last       = 1'b0;
        push         = 1'b0;
        div_start    = 1'b0;
        div_dividend = r_mag;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_neg   = value_u[VALUE_W-1];
                    n_mag   = value_u[VALUE_W-1] ? (~value_u + VALUE_W'(1)) : value_u;
                    n_nd    = '0;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (chk.done) begin
                    if (r_neg) begin
                        n_strobe = 1'b1;
                        n_ch     = CH_MINUS;
                        n_last   = !chk.ok;
                    end
                    if (chk.ok) begin
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DIV: begin
                if (div.done) begin
                    push = 1'b1;
                    n_nd = r_nd + DIGIT_PTR_W'(1);
                    if ((div.quot == '0) || (r_nd == DIGIT_PTR_W'(MAX_DIGITS - 1))) begin
                        n_state = S_EMIT;
                    end else begin
                        div_start    = 1'b1;
                        div_dividend = div.quot;
                    end
                end
            end
            S_EMIT: begin
                n_strobe = 1'b1;
                n_ch     = digit_char;
                n_last   = (r_nd == DIGIT_PTR_W'(1));
                n_nd     = rd_ptr;
                if (r_nd == DIGIT_PTR_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_nd     <= '0;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_nd     <= n_nd;
            r_strobe <= n_strobe;
            r_last   <= n_last;
        end
    end

    // The top of the stack is read ahead into a register, from the next stack depth; a push
    // goes straight into the top register as well.
    always_ff @(posedge i_clk) begin
        r_neg <= n_neg;
        r_mag <= n_mag;
        r_ch  <= n_ch;
        if (push) begin
            r_digits[r_nd[DIGIT_IDX_W-1:0]] <= div.rem[IDX_W-1:0];
            r_top_digit                     <= div.rem[IDX_W-1:0];
        end else begin
            r_top_digit <= r_digits[top_ptr[DIGIT_IDX_W-1:0]];
        end
    end

    assign o_strobe = r_strobe;
    assign o_ch     = r_ch;
    assign o_last   = r_last;

    `SI2BD_ASSERT_IMPL(a_top_last_strobe, o_last, o_strobe, "last flag without a word")
    `SI2BD_ASSERT_NEXT(a_top_accept_busy, start && !busy, busy, "accepted word did not go busy")
    `SI2BD_ASSERT_IMPL(a_top_emit_nonempty, r_state == S_EMIT, r_nd != '0,
        "emit phase with an empty digit stack")
    `SI2BD_ASSERT_IMPL(a_top_idle_word_last, o_strobe && !busy, o_last,
        "word shown while idle is not the last one")

endmodule
